// ----- rtl/fla_pkg.sv -----
package fla_pkg;

   // heap geometry
   localparam int unsigned HEAP_BYTES      = 65536;
   localparam int unsigned HEAP_WORDS      = HEAP_BYTES / 4;
   localparam int unsigned WORD_AW         = $clog2(HEAP_WORDS);
   localparam int unsigned OFF_W           = $clog2(HEAP_BYTES) + 1;
   localparam int unsigned WALK_MAX        = HEAP_BYTES / 16;
   localparam int unsigned WALK_W          = $clog2(WALK_MAX) + 1;
   localparam int unsigned MIN_BLOCK_BYTES = 16;
   localparam int unsigned FIRST_PAYLOAD   = 16;
   localparam int unsigned INIT_BREAK      = 32;
   localparam int unsigned WORD_W          = 32;

   // field widths
   localparam int unsigned REQ_W   = 17;
   localparam int unsigned BADDR_W = 16;
   localparam int unsigned PADDR_W = 16;
   localparam int unsigned LIMIT_W = 17;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CW      = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

   // codes
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;
   localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_OOM  = 2'd2;
   localparam logic [1:0] REG_HEAP_LIMIT = 2'd0;

   typedef struct packed {
      logic               kind;
      logic [REQ_W-1:0]   request_size;
      logic [BADDR_W-1:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [PADDR_W-1:0] payload_addr;
      logic [STAT_W-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [OFF_W-1:0]  addr;
      logic [WORD_W-1:0] wdata;
   } mem_req_type;

   typedef enum logic [5:0] {
      ST_CLEAR, ST_IDLE, ST_ASTART, ST_FF_CHK, ST_FF_SZ, ST_FF_NX,
      ST_GROW, ST_G_T2, ST_G_EPI,
      ST_PL_START, ST_PL_CS, ST_PL_SPLIT, ST_PN_2, ST_PS_2, ST_PS_3, ST_PS_4,
      ST_M_0, ST_M_1, ST_M_2, ST_M_3, ST_M_4, ST_M_5,
      ST_M_T1, ST_M_T2, ST_M_P1, ST_M_P2, ST_M_P3,
      ST_L_0, ST_L_1, ST_L_2, ST_L_3,
      ST_R_START, ST_R_CHK, ST_R_SZ, ST_R_T1, ST_R_T2,
      ST_DONE
   } state_type;

   // heap image after reset: prologue, one free block, epilogue
   function automatic logic [WORD_W-1:0] init_word(input logic [WORD_AW-1:0] idx);
      logic [WORD_W-1:0] w;
      case (idx)
         WORD_AW'(1), WORD_AW'(2): w = WORD_W'(9);
         WORD_AW'(3), WORD_AW'(6): w = WORD_W'(16);
         WORD_AW'(7):              w = WORD_W'(1);
         default:                  w = '0;
      endcase
      return w;
   endfunction

   function automatic mem_req_type mem_rd(input logic [OFF_W-1:0] a);
      mem_req_type m;
      m.en    = 1'b1;
      m.we    = 1'b0;
      m.addr  = a;
      m.wdata = '0;
      return m;
   endfunction

   function automatic mem_req_type mem_wr(input logic [OFF_W-1:0] a,
                                          input logic [WORD_W-1:0] d);
      mem_req_type m;
      m.en    = 1'b1;
      m.we    = 1'b1;
      m.addr  = a;
      m.wdata = d;
      return m;
   endfunction

endpackage

// ----- rtl/fla_ram.sv -----
module fla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

// ----- rtl/fla_csr.sv -----
module fla_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [1:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output logic [fla_pkg::LIMIT_W-1:0]  heap_limit
);

   logic [fla_pkg::LIMIT_W-1:0] limit_ff;
   logic [fla_pkg::LIMIT_W-1:0] limit_in;
   logic                        wr_beat;

   // write beat on the access phase; one register, all addresses map to it
   assign wr_beat = psel & penable & pwrite & (paddr[1:0] == fla_pkg::REG_HEAP_LIMIT
                                                || paddr != fla_pkg::REG_HEAP_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (wr_beat) begin
         limit_in = pwdata[fla_pkg::LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= fla_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata     = 32'(limit_ff);
   assign pready     = 1'b1;
   assign heap_limit = limit_ff;

endmodule

// ----- rtl/fla_engine.sv -----
module fla_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  fla_pkg::req_type            req,
   input  logic [fla_pkg::LIMIT_W-1:0] heap_limit,
   output logic                        done,
   output fla_pkg::rsp_type            res,
   input  logic                        out_ready
);

   localparam int unsigned OW = fla_pkg::OFF_W;
   localparam int unsigned CW = fla_pkg::CW;

   fla_pkg::state_type state_ff, state_in;
   fla_pkg::state_type lr_ret_ff, lr_ret_in;
   fla_pkg::state_type mg_ret_ff, mg_ret_in;

   logic [fla_pkg::WORD_AW-1:0] clr_ff, clr_in;
   logic [OW-1:0]  head_ff, head_in;
   logic [OW-1:0]  brk_ff, brk_in;
   logic [OW-1:0]  cur_ff, cur_in;
   logic [fla_pkg::WALK_W-1:0] n_ff, n_in;
   logic [OW-1:0]  bp_ff, bp_in;
   logic [OW-1:0]  mbp_ff, mbp_in;
   logic [OW-1:0]  msize_ff, msize_in;
   logic [OW-1:0]  csize_ff, csize_in;
   logic [OW-1:0]  pfoot_ff, pfoot_in;
   logic [OW-1:0]  lr_x_ff, lr_x_in;
   logic [fla_pkg::WORD_W-1:0] lr_nx_ff, lr_nx_in;
   logic [fla_pkg::WORD_W-1:0] lr_pv_ff, lr_pv_in;
   logic [OW-1:0]  rq_addr_ff, rq_addr_in;
   logic [CW-1:0]  asize_ff, asize_in;
   logic           zero_ff, zero_in;
   logic [fla_pkg::PADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [fla_pkg::STAT_W-1:0]  res_status_ff, res_status_in;
   logic           oob_ff;

   fla_pkg::mem_req_type mem;
   logic [fla_pkg::WORD_W-1:0] ram_rdata;
   logic [fla_pkg::WORD_W-1:0] rd_w;
   logic           in_range;

   // derived terms
   logic [OW-1:0]  sz_rd;
   logic [OW-1:0]  pf_size;
   logic [OW-1:0]  asize_t;
   logic [OW-1:0]  rem;
   logic [CW-1:0]  nbrk;
   logic [CW-1:0]  limit_eff;
   logic [CW-1:0]  rq_ext;
   logic [CW-1:0]  rq_round;
   logic [CW-1:0]  asize_calc;
   logic           walk_end;
   logic           fits;
   logic           oom;
   logic           split;
   logic           r_end;
   logic           r_bad;
   logic           r_hit;
   logic           below_free;

   // heap memory, one port
   assign in_range = ~mem.addr[OW-1];

   fla_ram #(
      .WIDTH(fla_pkg::WORD_W),
      .DEPTH(fla_pkg::HEAP_WORDS)
   ) u_heap (
      .clock(clock),
      .en(mem.en & in_range),
      .we(mem.we),
      .addr(mem.addr[fla_pkg::WORD_AW+1:2]),
      .wdata(mem.wdata),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      oob_ff <= mem.en & ~mem.we & ~in_range;
   end

   assign rd_w = oob_ff ? '0 : ram_rdata;

   assign sz_rd     = {rd_w[OW-1:3], 3'b000};
   assign pf_size   = {pfoot_ff[OW-1:3], 3'b000};
   assign asize_t   = asize_ff[OW-1:0];
   assign rem       = csize_ff - asize_t;
   assign nbrk      = CW'(brk_ff) + asize_ff;
   assign limit_eff = (CW'(heap_limit) > CW'(fla_pkg::HEAP_BYTES)) ?
                      CW'(fla_pkg::HEAP_BYTES) : CW'(heap_limit);
   assign rq_ext    = CW'(req.request_size);
   assign rq_round  = rq_ext + CW'(7);
   assign asize_calc = {rq_round[CW-1:3], 3'b000} + CW'(8);

   assign walk_end  = (n_ff == fla_pkg::WALK_W'(fla_pkg::WALK_MAX)) || (cur_ff == '0);
   assign fits      = CW'(sz_rd) >= asize_ff;
   assign oom       = nbrk > limit_eff;
   assign split     = rem >= OW'(fla_pkg::MIN_BLOCK_BYTES);
   assign r_end     = (n_ff == fla_pkg::WALK_W'(fla_pkg::WALK_MAX)) || (cur_ff >= brk_ff);
   assign r_bad     = (sz_rd == '0) || (cur_ff > rq_addr_ff);
   assign r_hit     = cur_ff == rq_addr_ff;
   assign below_free = ~pfoot_ff[0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fla_pkg::ST_CLEAR:    if (clr_ff == '1) state_in = fla_pkg::ST_IDLE;
         fla_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req.kind == fla_pkg::KIND_FREE) ? fla_pkg::ST_R_START
                                                           : fla_pkg::ST_ASTART;
            end
         end
         fla_pkg::ST_ASTART:   state_in = zero_ff ? fla_pkg::ST_DONE : fla_pkg::ST_FF_CHK;
         fla_pkg::ST_FF_CHK:   state_in = walk_end ? fla_pkg::ST_GROW : fla_pkg::ST_FF_SZ;
         fla_pkg::ST_FF_SZ:    state_in = fits ? fla_pkg::ST_PL_START : fla_pkg::ST_FF_NX;
         fla_pkg::ST_FF_NX:    state_in = fla_pkg::ST_FF_CHK;
         fla_pkg::ST_GROW:     state_in = oom ? fla_pkg::ST_DONE : fla_pkg::ST_G_T2;
         fla_pkg::ST_G_T2:     state_in = fla_pkg::ST_G_EPI;
         fla_pkg::ST_G_EPI:    state_in = fla_pkg::ST_M_0;
         fla_pkg::ST_PL_START: state_in = fla_pkg::ST_PL_CS;
         fla_pkg::ST_PL_CS:    state_in = fla_pkg::ST_L_0;
         fla_pkg::ST_PL_SPLIT: state_in = split ? fla_pkg::ST_PS_2 : fla_pkg::ST_PN_2;
         fla_pkg::ST_PN_2:     state_in = fla_pkg::ST_DONE;
         fla_pkg::ST_PS_2:     state_in = fla_pkg::ST_PS_3;
         fla_pkg::ST_PS_3:     state_in = fla_pkg::ST_PS_4;
         fla_pkg::ST_PS_4:     state_in = fla_pkg::ST_M_0;
         fla_pkg::ST_M_0:      state_in = fla_pkg::ST_M_1;
         fla_pkg::ST_M_1:      state_in = fla_pkg::ST_M_2;
         fla_pkg::ST_M_2:      state_in = fla_pkg::ST_M_3;
         fla_pkg::ST_M_3:      state_in = rd_w[0] ? fla_pkg::ST_M_4 : fla_pkg::ST_L_0;
         fla_pkg::ST_M_4:      state_in = below_free ? fla_pkg::ST_M_5 : fla_pkg::ST_M_T1;
         fla_pkg::ST_M_5:      state_in = fla_pkg::ST_L_0;
         fla_pkg::ST_M_T1:     state_in = fla_pkg::ST_M_T2;
         fla_pkg::ST_M_T2:     state_in = fla_pkg::ST_M_P1;
         fla_pkg::ST_M_P1:     state_in = fla_pkg::ST_M_P2;
         fla_pkg::ST_M_P2:     state_in = fla_pkg::ST_M_P3;
         fla_pkg::ST_M_P3:     state_in = mg_ret_ff;
         fla_pkg::ST_L_0:      state_in = fla_pkg::ST_L_1;
         fla_pkg::ST_L_1:      state_in = fla_pkg::ST_L_2;
         fla_pkg::ST_L_2:      state_in = fla_pkg::ST_L_3;
         fla_pkg::ST_L_3:      state_in = lr_ret_ff;
         fla_pkg::ST_R_START:  state_in = fla_pkg::ST_R_CHK;
         fla_pkg::ST_R_CHK:    state_in = r_end ? fla_pkg::ST_DONE : fla_pkg::ST_R_SZ;
         fla_pkg::ST_R_SZ: begin
            if (r_bad) begin
               state_in = fla_pkg::ST_DONE;
            end else if (r_hit) begin
               state_in = rd_w[0] ? fla_pkg::ST_R_T1 : fla_pkg::ST_DONE;
            end else begin
               state_in = fla_pkg::ST_R_CHK;
            end
         end
         fla_pkg::ST_R_T1:     state_in = fla_pkg::ST_R_T2;
         fla_pkg::ST_R_T2:     state_in = fla_pkg::ST_M_0;
         fla_pkg::ST_DONE:     if (out_ready) state_in = fla_pkg::ST_IDLE;
         default:              state_in = fla_pkg::ST_IDLE;
      endcase
   end

   // memory accesses and datapath updates
   always_comb begin
      mem           = '0;
      clr_in        = clr_ff;
      head_in       = head_ff;
      brk_in        = brk_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      bp_in         = bp_ff;
      mbp_in        = mbp_ff;
      msize_in      = msize_ff;
      csize_in      = csize_ff;
      pfoot_in      = pfoot_ff;
      lr_x_in       = lr_x_ff;
      lr_nx_in      = lr_nx_ff;
      lr_pv_in      = lr_pv_ff;
      lr_ret_in     = lr_ret_ff;
      mg_ret_in     = mg_ret_ff;
      rq_addr_in    = rq_addr_ff;
      asize_in      = asize_ff;
      zero_in       = zero_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         // sweep the reset image into the heap
         fla_pkg::ST_CLEAR: begin
            mem    = fla_pkg::mem_wr(OW'({clr_ff, 2'b00}), fla_pkg::init_word(clr_ff));
            clr_in = clr_ff + 1'b1;
         end
         fla_pkg::ST_IDLE: begin
            rq_addr_in    = OW'(req.block_addr);
            zero_in       = req.request_size == '0;
            asize_in      = (asize_calc < CW'(fla_pkg::MIN_BLOCK_BYTES)) ?
                            CW'(fla_pkg::MIN_BLOCK_BYTES) : asize_calc;
            res_addr_in   = '0;
            res_status_in = fla_pkg::STATUS_OK;
         end
         fla_pkg::ST_ASTART: begin
            cur_in = head_ff;
            n_in   = '0;
            if (zero_ff) res_status_in = fla_pkg::STATUS_ZERO;
         end
         // first-fit walk of the free list
         fla_pkg::ST_FF_CHK: begin
            if (!walk_end) mem = fla_pkg::mem_rd(cur_ff - OW'(4));
         end
         fla_pkg::ST_FF_SZ: begin
            if (fits) begin
               mbp_in = cur_ff;
            end else begin
               mem = fla_pkg::mem_rd(cur_ff);
            end
         end
         fla_pkg::ST_FF_NX: begin
            cur_in = rd_w[OW-1:0];
            n_in   = n_ff + 1'b1;
         end
         // grow at the break
         fla_pkg::ST_GROW: begin
            if (oom) begin
               res_status_in = fla_pkg::STATUS_OOM;
            end else begin
               mem    = fla_pkg::mem_wr(brk_ff - OW'(4), 32'(asize_t));
               mbp_in = brk_ff;
            end
         end
         fla_pkg::ST_G_T2: begin
            mem = fla_pkg::mem_wr(mbp_ff + asize_t - OW'(8), 32'(asize_t));
         end
         fla_pkg::ST_G_EPI: begin
            mem       = fla_pkg::mem_wr(nbrk[OW-1:0] - OW'(4), 32'(1));
            brk_in    = nbrk[OW-1:0];
            mg_ret_in = fla_pkg::ST_PL_START;
         end
         // place: unlink, then split or take whole
         fla_pkg::ST_PL_START: begin
            bp_in = mbp_ff;
            mem   = fla_pkg::mem_rd(mbp_ff - OW'(4));
         end
         fla_pkg::ST_PL_CS: begin
            csize_in  = sz_rd;
            lr_x_in   = bp_ff;
            lr_ret_in = fla_pkg::ST_PL_SPLIT;
         end
         fla_pkg::ST_PL_SPLIT: begin
            if (split) begin
               mem = fla_pkg::mem_wr(bp_ff - OW'(4), 32'({asize_t[OW-1:1], 1'b1}));
            end else begin
               mem = fla_pkg::mem_wr(bp_ff - OW'(4), 32'({csize_ff[OW-1:1], 1'b1}));
            end
         end
         fla_pkg::ST_PN_2: begin
            mem         = fla_pkg::mem_wr(bp_ff + csize_ff - OW'(8),
                                          32'({csize_ff[OW-1:1], 1'b1}));
            res_addr_in = fla_pkg::PADDR_W'(bp_ff);
         end
         fla_pkg::ST_PS_2: begin
            mem = fla_pkg::mem_wr(bp_ff + asize_t - OW'(8), 32'({asize_t[OW-1:1], 1'b1}));
         end
         fla_pkg::ST_PS_3: begin
            mem = fla_pkg::mem_wr(bp_ff + asize_t - OW'(4), 32'(rem));
         end
         fla_pkg::ST_PS_4: begin
            mem         = fla_pkg::mem_wr(bp_ff + csize_ff - OW'(8), 32'(rem));
            mbp_in      = bp_ff + asize_t;
            mg_ret_in   = fla_pkg::ST_DONE;
            res_addr_in = fla_pkg::PADDR_W'(bp_ff);
         end
         // coalesce with free neighbors, push at head
         fla_pkg::ST_M_0: mem = fla_pkg::mem_rd(mbp_ff - OW'(4));
         fla_pkg::ST_M_1: begin
            msize_in = sz_rd;
            mem      = fla_pkg::mem_rd(mbp_ff - OW'(8));
         end
         fla_pkg::ST_M_2: begin
            pfoot_in = rd_w[OW-1:0];
            mem      = fla_pkg::mem_rd(mbp_ff + msize_ff - OW'(4));
         end
         fla_pkg::ST_M_3: begin
            if (!rd_w[0]) begin
               msize_in  = msize_ff + sz_rd;
               lr_x_in   = mbp_ff + msize_ff;
               lr_ret_in = fla_pkg::ST_M_4;
            end
         end
         fla_pkg::ST_M_4: begin
            if (below_free) begin
               mbp_in = mbp_ff - pf_size;
               mem    = fla_pkg::mem_rd(mbp_ff - pf_size - OW'(4));
            end
         end
         fla_pkg::ST_M_5: begin
            msize_in  = msize_ff + sz_rd;
            lr_x_in   = mbp_ff;
            lr_ret_in = fla_pkg::ST_M_T1;
         end
         fla_pkg::ST_M_T1: mem = fla_pkg::mem_wr(mbp_ff - OW'(4), 32'(msize_ff));
         fla_pkg::ST_M_T2: mem = fla_pkg::mem_wr(mbp_ff + msize_ff - OW'(8), 32'(msize_ff));
         fla_pkg::ST_M_P1: mem = fla_pkg::mem_wr(mbp_ff, 32'(head_ff));
         fla_pkg::ST_M_P2: mem = fla_pkg::mem_wr(mbp_ff + OW'(4), '0);
         fla_pkg::ST_M_P3: begin
            if (head_ff != '0) mem = fla_pkg::mem_wr(head_ff + OW'(4), 32'(mbp_ff));
            head_in = mbp_ff;
         end
         // unlink lr_x from the free list
         fla_pkg::ST_L_0: mem = fla_pkg::mem_rd(lr_x_ff);
         fla_pkg::ST_L_1: begin
            lr_nx_in = rd_w;
            mem      = fla_pkg::mem_rd(lr_x_ff + OW'(4));
         end
         fla_pkg::ST_L_2: begin
            lr_pv_in = rd_w;
            if (rd_w != '0) begin
               mem = fla_pkg::mem_wr(rd_w[OW-1:0], lr_nx_ff);
            end else begin
               head_in = lr_nx_ff[OW-1:0];
            end
         end
         fla_pkg::ST_L_3: begin
            if (lr_nx_ff != '0) mem = fla_pkg::mem_wr(lr_nx_ff[OW-1:0] + OW'(4), lr_pv_ff);
         end
         // release: confirm the block by walking from the first one
         fla_pkg::ST_R_START: begin
            cur_in = OW'(fla_pkg::FIRST_PAYLOAD);
            n_in   = '0;
         end
         fla_pkg::ST_R_CHK: begin
            if (!r_end) mem = fla_pkg::mem_rd(cur_ff - OW'(4));
         end
         fla_pkg::ST_R_SZ: begin
            if (!r_bad && r_hit) begin
               csize_in = sz_rd;
               mbp_in   = cur_ff;
            end else if (!r_bad) begin
               cur_in = cur_ff + sz_rd;
               n_in   = n_ff + 1'b1;
            end
         end
         fla_pkg::ST_R_T1: mem = fla_pkg::mem_wr(mbp_ff - OW'(4), 32'(csize_ff));
         fla_pkg::ST_R_T2: begin
            mem       = fla_pkg::mem_wr(mbp_ff + csize_ff - OW'(8), 32'(csize_ff));
            mg_ret_in = fla_pkg::ST_DONE;
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fla_pkg::ST_CLEAR;
         lr_ret_ff <= fla_pkg::ST_DONE;
         mg_ret_ff <= fla_pkg::ST_DONE;
         clr_ff    <= '0;
         head_ff   <= OW'(fla_pkg::FIRST_PAYLOAD);
         brk_ff    <= OW'(fla_pkg::INIT_BREAK);
      end else begin
         state_ff  <= state_in;
         lr_ret_ff <= lr_ret_in;
         mg_ret_ff <= mg_ret_in;
         clr_ff    <= clr_in;
         head_ff   <= head_in;
         brk_ff    <= brk_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      n_ff          <= n_in;
      bp_ff         <= bp_in;
      mbp_ff        <= mbp_in;
      msize_ff      <= msize_in;
      csize_ff      <= csize_in;
      pfoot_ff      <= pfoot_in;
      lr_x_ff       <= lr_x_in;
      lr_nx_ff      <= lr_nx_in;
      lr_pv_ff      <= lr_pv_in;
      rq_addr_ff    <= rq_addr_in;
      asize_ff      <= asize_in;
      zero_ff       <= zero_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

   assign req_ready        = state_ff == fla_pkg::ST_IDLE;
   assign done             = state_ff == fla_pkg::ST_DONE;
   assign res.payload_addr = res_addr_ff;
   assign res.status       = res_status_ff;

endmodule

// ----- rtl/free_list_heap_allocator.sv -----
// Accept to result valid: a zero-size allocate skips the free-list walk; an allocate walks
//   the free list entry by entry, then takes the block whole or splits it, and the split-off
//   remainder may merge with free neighbours; growth at the break merges, then places; out of
//   memory ends after the walk; release walks the blocks from the first one, then merges.
// Throughput: one request at a time; the next beat can be taken once the result is valid.
// Reset: heap_limit 65536; the whole heap image is swept in before the first beat.
module free_list_heap_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  fla_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output fla_pkg::rsp_type            rsp_payload,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [1:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic [fla_pkg::LIMIT_W-1:0] heap_limit;
   logic                        eng_done;
   fla_pkg::rsp_type            eng_res;
   logic                        out_ready;
   logic                        rsp_valid_ff, rsp_valid_in;
   fla_pkg::rsp_type            rsp_ff, rsp_in;

   fla_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .heap_limit(heap_limit)
   );

   fla_engine u_engine (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req(req_payload),
      .heap_limit(heap_limit),
      .done(eng_done),
      .res(eng_res),
      .out_ready(out_ready)
   );

   // result register between the engine and the consumer
   assign out_ready = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      if (eng_done && out_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // one request in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while engine busy");

   // a failed or empty allocate never carries an address
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != fla_pkg::STATUS_OK |-> rsp_payload.payload_addr == '0)
      else $error("address on a non-ok result");

   // status is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == fla_pkg::STATUS_OK ||
                     rsp_payload.status == fla_pkg::STATUS_ZERO ||
                     rsp_payload.status == fla_pkg::STATUS_OOM))
      else $error("undefined status code");

   // engine only finishes into a free result slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("pending result overwritten");

endmodule
